### rtl/btt_pkg.sv
// ---------------------------------------------------------------------------
// btt_pkg: shared definitions for the bounded tie table
// Field widths, operation and register codes, and the command and status
// records that pass between the controller and the datapath.
// ---------------------------------------------------------------------------
package btt_pkg;

  localparam int NODES_DEF = 256;
  localparam int SLOTS_DEF = 8;

  localparam int OP_W      = 3;
  localparam int NODE_W    = 8;
  localparam int KIND_W    = 3;
  localparam int AMT_W     = 32;
  localparam int SLOT_W    = 3;
  localparam int CNT_W     = 4;
  localparam int WGT_W     = 8;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 32;

  localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
  localparam logic [OP_W-1:0] OP_LINK   = 3'd1;
  localparam logic [OP_W-1:0] OP_ADJUST = 3'd2;
  localparam logic [OP_W-1:0] OP_READ   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_NODES_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_MIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_MAX   = 2'd2;

  localparam logic [CFG_W-1:0]        NODES_IN_USE_RST = 9'd256;
  localparam logic signed [WGT_W-1:0] WEIGHT_MIN_RST   = -8'sd128;
  localparam logic signed [WGT_W-1:0] WEIGHT_MAX_RST   = 8'sd127;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic fill_rd;
    logic fill_take;
    logic clear_all;
    logic scan_start;
    logic edge_rd_scan;
    logic edge_rd_slot;
    logic scan_step;
    logic upd;
    logic set_pass1;
    logic read_hit;
    logic out_load;
  } btt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            pass1;
    logic            pass_ok;
    logic            pair_ok;
    logic            read_ok;
    logic            fill_zero;
    logic            hit;
    logic            scan_last;
    logic            out_free;
  } btt_stat_t;

endpackage

### rtl/btt_ctrl.sv
// ---------------------------------------------------------------------------
// btt_ctrl: sequencing state machine of the bounded tie table
// Steps each operation through row fetch, any scan and update, and result.
// ---------------------------------------------------------------------------
module btt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  btt_pkg::btt_stat_t   stat,
  output btt_pkg::btt_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FILL  = 3'd1;
  localparam logic [2:0] S_FILLW = 3'd2;
  localparam logic [2:0] S_SCANA = 3'd3;
  localparam logic [2:0] S_SCANC = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        cmd.fill_rd = 1'b1;
        state_nxt   = S_FILLW;
      end
      S_FILLW: begin
        cmd.fill_take = 1'b1;
        state_nxt     = S_FIN;
        unique case (stat.op) inside
          btt_pkg::OP_ADD, btt_pkg::OP_LINK: begin
            if (stat.pass_ok) begin
              cmd.scan_start = 1'b1;
              state_nxt      = stat.fill_zero ? S_UPD : S_SCANA;
            end else if (stat.op == btt_pkg::OP_LINK && !stat.pass1) begin
              cmd.set_pass1 = 1'b1;
              state_nxt     = S_FILL;
            end
          end
          btt_pkg::OP_ADJUST: begin
            if (stat.pair_ok && !stat.fill_zero) begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCANA;
            end
          end
          btt_pkg::OP_READ: begin
            if (stat.read_ok) begin
              cmd.read_hit     = 1'b1;
              cmd.edge_rd_slot = 1'b1;
            end
          end
          btt_pkg::OP_CLEAR: begin
            cmd.clear_all = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_SCANA: begin
        cmd.edge_rd_scan = 1'b1;
        state_nxt        = S_SCANC;
      end
      S_SCANC: begin
        cmd.scan_step = 1'b1;
        state_nxt     = (stat.hit || stat.scan_last) ? S_UPD : S_SCANA;
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        if (stat.op == btt_pkg::OP_LINK && !stat.pass1) begin
          cmd.set_pass1 = 1'b1;
          state_nxt     = S_FILL;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_FILL))
    else $error("accepted transaction did not start a row fetch");

  a_scan_op: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCANA) |-> (stat.op == btt_pkg::OP_ADD || stat.op == btt_pkg::OP_LINK ||
                              stat.op == btt_pkg::OP_ADJUST))
    else $error("slot scan entered for an operation that does not search");

  a_reverse_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.set_pass1 |-> (stat.op == btt_pkg::OP_LINK && !stat.pass1))
    else $error("reverse pass started outside the forward pass of a link");

endmodule

### rtl/btt_datapath.sv
// ---------------------------------------------------------------------------
// btt_datapath: registers, row stores and arithmetic of the bounded tie table
// Holds the configuration, the per-row fill counts with their valid flags,
// the edge store, the clamp logic and the result register.
// ---------------------------------------------------------------------------
module btt_datapath #(
  parameter int NODES = btt_pkg::NODES_DEF,
  parameter int SLOTS = btt_pkg::SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [btt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [btt_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic [btt_pkg::IN_DATA_W-1:0]       in_tdata,
  input  btt_pkg::btt_cmd_t                   cmd,
  output btt_pkg::btt_stat_t                  stat,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [btt_pkg::OUT_DATA_W-1:0]      out_tdata
);

  localparam int NW   = $clog2(NODES);
  localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FW   = $clog2(SLOTS + 1);
  localparam int AW   = NW + SW;
  localparam int EW   = btt_pkg::NODE_W + btt_pkg::KIND_W + btt_pkg::WGT_W;
  localparam int XW   = btt_pkg::AMT_W + 1;
  localparam int OUT_USED = 2 + btt_pkg::CNT_W + btt_pkg::NODE_W + btt_pkg::KIND_W +
                            btt_pkg::WGT_W;

  // Input field offsets within in_tdata.
  localparam int FROM_LO = btt_pkg::OP_W;
  localparam int TO_LO   = FROM_LO + btt_pkg::NODE_W;
  localparam int KIND_LO = TO_LO + btt_pkg::NODE_W;
  localparam int AMT_LO  = KIND_LO + btt_pkg::KIND_W;
  localparam int SLOT_LO = AMT_LO + btt_pkg::AMT_W;

  // Configuration registers.
  logic [btt_pkg::CFG_W-1:0]        nodes_in_use_r;
  logic signed [btt_pkg::WGT_W-1:0] weight_min_r;
  logic signed [btt_pkg::WGT_W-1:0] weight_max_r;

  // Captured transaction.
  logic [btt_pkg::OP_W-1:0]          op_r;
  logic [btt_pkg::NODE_W-1:0]        from_r;
  logic [btt_pkg::NODE_W-1:0]        to_r;
  logic [btt_pkg::KIND_W-1:0]        kind_r;
  logic signed [btt_pkg::AMT_W-1:0]  amount_r;
  logic [btt_pkg::SLOT_W-1:0]        slot_in_r;

  // Working registers.
  logic          pass_r;
  logic [SW-1:0] k_r;
  logic [SW-1:0] slot_r;
  logic          found_r;
  logic [FW-1:0] fill_r;
  logic [FW-1:0] from_cnt_r;
  logic          ok_r;
  logic          okr_r;

  // Row fill store with one valid flag per row.
  logic [FW-1:0]    fill_mem [NODES];
  logic [FW-1:0]    fill_q_r;
  logic             fill_v_r;
  logic [NODES-1:0] valid_r;

  // Edge store: {target, kind, weight} per slot.
  logic [EW-1:0] edge_mem [NODES * (2 ** SW)];
  logic [EW-1:0] edge_q_r;

  logic                             out_valid_r;
  logic [btt_pkg::OUT_DATA_W-1:0]   out_data_r;

  logic [btt_pkg::NODE_W-1:0]       node_a;
  logic [btt_pkg::NODE_W-1:0]       node_b;
  logic [NW-1:0]                    a_idx;
  logic                             a_ok;
  logic                             b_ok;
  logic                             from_ok;
  logic [FW-1:0]                    fill_now;
  logic                             row_full;
  logic [btt_pkg::NODE_W-1:0]       e_tgt;
  logic [btt_pkg::KIND_W-1:0]       e_kind;
  logic signed [btt_pkg::WGT_W-1:0] e_wgt;
  logic signed [XW-1:0]             sum_w;
  logic signed [XW-1:0]             clamp_w;
  logic                             is_adjust;
  logic                             edge_we;
  logic [AW-1:0]                    edge_waddr;
  logic [EW-1:0]                    edge_wdata;
  logic                             edge_re;
  logic [AW-1:0]                    edge_raddr;
  logic                             fill_we;
  logic [FW-1:0]                    fill_inc;
  logic                             upd_ok;
  logic [btt_pkg::CNT_W-1:0]        cnt_out;
  logic                             show_edge;

  function automatic logic node_ok(input logic [btt_pkg::NODE_W-1:0] n,
                                   input logic [btt_pkg::CFG_W-1:0]  lim);
    return ({1'b0, n} < lim) && (int'(n) < NODES);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodes_in_use_r <= btt_pkg::NODES_IN_USE_RST;
      weight_min_r   <= btt_pkg::WEIGHT_MIN_RST;
      weight_max_r   <= btt_pkg::WEIGHT_MAX_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        btt_pkg::REG_NODES_IN_USE: nodes_in_use_r <= cfg_wdata;
        btt_pkg::REG_WEIGHT_MIN:   weight_min_r   <= cfg_wdata[btt_pkg::WGT_W-1:0];
        btt_pkg::REG_WEIGHT_MAX:   weight_max_r   <= cfg_wdata[btt_pkg::WGT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign node_a    = pass_r ? to_r : from_r;
  assign node_b    = pass_r ? from_r : to_r;
  assign a_idx     = NW'(node_a);
  assign a_ok      = node_ok(node_a, nodes_in_use_r);
  assign b_ok      = node_ok(node_b, nodes_in_use_r);
  assign from_ok   = node_ok(from_r, nodes_in_use_r);
  assign fill_now  = fill_v_r ? fill_q_r : '0;
  assign row_full  = (int'(fill_r) >= SLOTS);
  assign is_adjust = (op_r == btt_pkg::OP_ADJUST);
  assign fill_inc  = fill_r + FW'(1);

  assign e_tgt  = edge_q_r[EW-1 -: btt_pkg::NODE_W];
  assign e_kind = edge_q_r[btt_pkg::WGT_W +: btt_pkg::KIND_W];
  assign e_wgt  = edge_q_r[btt_pkg::WGT_W-1:0];

  // Forms the new weight at full width, then caps at the upper bound and
  // raises to the lower bound.
  always_comb begin
    if (is_adjust) begin
      sum_w = XW'(e_wgt) + XW'(amount_r);
    end else begin
      sum_w = XW'(amount_r);
    end
    clamp_w = sum_w;
    if (clamp_w > XW'(weight_max_r)) begin
      clamp_w = XW'(weight_max_r);
    end
    if (clamp_w < XW'(weight_min_r)) begin
      clamp_w = XW'(weight_min_r);
    end
  end

  assign upd_ok     = is_adjust ? found_r : (found_r || !row_full);
  assign edge_we    = cmd.upd && upd_ok;
  assign edge_waddr = found_r ? {a_idx, slot_r} : {a_idx, SW'(fill_r)};
  assign edge_wdata = {node_b, (is_adjust ? e_kind : kind_r),
                       clamp_w[btt_pkg::WGT_W-1:0]};
  assign fill_we    = cmd.upd && !is_adjust && !found_r && !row_full;
  assign edge_re    = cmd.edge_rd_scan || cmd.edge_rd_slot;
  assign edge_raddr = cmd.edge_rd_slot ? {a_idx, SW'(slot_in_r)} : {a_idx, k_r};

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= edge_wdata;
    end
    if (edge_re) begin
      edge_q_r <= edge_mem[edge_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[a_idx] <= fill_inc;
    end
    if (cmd.fill_rd) begin
      fill_q_r <= fill_mem[a_idx];
      fill_v_r <= valid_r[a_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.clear_all) begin
      valid_r <= '0;
    end else if (fill_we) begin
      valid_r[a_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_r <= 1'b0;
      ok_r   <= 1'b0;
      okr_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        pass_r <= 1'b0;
        ok_r   <= 1'b0;
        okr_r  <= 1'b0;
      end
      if (cmd.set_pass1) begin
        pass_r <= 1'b1;
      end
      if (cmd.read_hit) begin
        ok_r <= 1'b1;
      end
      if (cmd.upd && upd_ok) begin
        if (pass_r) begin
          okr_r <= 1'b1;
        end else begin
          ok_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_tdata[btt_pkg::OP_W-1:0];
      from_r    <= in_tdata[FROM_LO +: btt_pkg::NODE_W];
      to_r      <= in_tdata[TO_LO +: btt_pkg::NODE_W];
      kind_r    <= in_tdata[KIND_LO +: btt_pkg::KIND_W];
      amount_r  <= in_tdata[AMT_LO +: btt_pkg::AMT_W];
      slot_in_r <= in_tdata[SLOT_LO +: btt_pkg::SLOT_W];
    end
    if (cmd.fill_take) begin
      fill_r <= fill_now;
      if (!pass_r) begin
        from_cnt_r <= fill_now;
      end
    end
    if (cmd.clear_all) begin
      from_cnt_r <= '0;
    end
    if (cmd.scan_start) begin
      k_r     <= '0;
      found_r <= 1'b0;
    end
    if (cmd.scan_step) begin
      if (e_tgt == node_b) begin
        found_r <= 1'b1;
        slot_r  <= k_r;
      end else begin
        k_r <= k_r + SW'(1);
      end
    end
    if (fill_we && !pass_r) begin
      from_cnt_r <= fill_inc;
    end
  end

  assign cnt_out   = from_ok ? btt_pkg::CNT_W'(from_cnt_r) : '0;
  assign show_edge = (op_r == btt_pkg::OP_READ) && ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {{(btt_pkg::OUT_DATA_W - OUT_USED){1'b0}},
                     (show_edge ? e_wgt : '0),
                     (show_edge ? e_kind : '0),
                     (show_edge ? e_tgt : '0),
                     cnt_out, okr_r, ok_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign stat.op        = op_r;
  assign stat.pass1     = pass_r;
  assign stat.pass_ok   = a_ok && b_ok && (node_a != node_b);
  assign stat.pair_ok   = a_ok && b_ok;
  assign stat.read_ok   = a_ok && (int'(slot_in_r) < int'(fill_now)) &&
                          (int'(slot_in_r) < SLOTS);
  assign stat.fill_zero = (fill_now == '0);
  assign stat.hit       = (e_tgt == node_b);
  assign stat.scan_last = ((FW'(k_r) + FW'(1)) == fill_r);
  assign stat.out_free  = !out_valid_r || out_tready;

  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    fill_we |-> (int'(fill_r) < SLOTS))
    else $error("edge appended to a full row");

  a_clear_flags: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_all |=> (valid_r == '0))
    else $error("row valid flags not cleared after a clear");

endmodule

### rtl/bounded_tie_table.sv
// ---------------------------------------------------------------------------
// bounded_tie_table: bounded per-node table of directed weighted edges
// Read, clear, unused codes, rejected adds and adjusts of an empty row go
//   from the row fetch straight to the result; other adds and adjusts
//   scan the filled slots of their row for the target, reading in S_SCANA
//   and comparing in S_SCANC, then update. A link runs the add twice.
// One transaction at a time: a new request is taken only after the last
//   one has loaded its result. Reset (synchronous, active low) restores the
//   configuration and control registers and marks every row empty at once
//   through per-row valid flags; no clearing pass.
// ---------------------------------------------------------------------------
module bounded_tie_table #(
  parameter int NODES = btt_pkg::NODES_DEF,
  parameter int SLOTS = btt_pkg::SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration write port: index 0 nodes_in_use, 1 weight_min, 2 weight_max.
  input  logic                            cfg_wr_en,
  input  logic [btt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [btt_pkg::CFG_W-1:0]       cfg_wdata,
  // Request stream.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // in_tdata, from bit 0 up: operation[2:0], from_node[10:3], to_node[18:11],
  // edge_kind[21:19], amount[53:22], slot_index[56:54], zeros above.
  input  logic [btt_pkg::IN_DATA_W-1:0]   in_tdata,
  // Result stream.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_tdata, from bit 0 up: ok[0], ok_reverse[1], row_count[5:2],
  // edge_target[13:6], edge_kind_out[16:14], edge_weight[24:17], zeros above.
  output logic [btt_pkg::OUT_DATA_W-1:0]  out_tdata
);

  // The controller decides the order of steps; the datapath owns every
  // stored value and reports the conditions the controller branches on.
  btt_pkg::btt_cmd_t  cmd;
  btt_pkg::btt_stat_t stat;

  // Requests are taken only between transactions. The result register in the
  // datapath lets a new request enter while the previous result still waits
  // for out_tready; the controller holds its final step until that register
  // is free.
  btt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Each pass of an add reads the row count, walks the row comparing targets,
  // then either rewrites the matching edge or, if the row has room, appends a
  // new one. A link repeats the pass with the nodes swapped. Weights are formed
  // at 33 bits and clamped to the configured bounds before they are stored.
  btt_datapath #(
    .NODES (NODES),
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule
